FILE: rtl/length_prefixed_request_deframer_top_assert.svh
// Assertion macros for the length-prefixed request deframer.
// Self-contained; included by the RTL file that carries assertions, the deframer top.
`ifndef LENGTH_PREFIXED_REQUEST_DEFRAMER_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_REQUEST_DEFRAMER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication: whenever ante holds, cons must hold too.
`define LPRD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define LPRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LPRD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define LPRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/lprd_pkg.sv
// Shared types and constants of the length-prefixed request deframer.
// No dependencies.
package lprd_pkg;

    typedef enum logic [3:0] {
        PH_BODY_LEN = 4'b0001,
        PH_COUNT    = 4'b0010,
        PH_ARG_LEN  = 4'b0100,
        PH_PAYLOAD  = 4'b1000
    } t_phase;

    localparam logic [1:0] ROLE_CTRL    = 2'd0;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd1;
    localparam logic [1:0] ROLE_DROP    = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
    localparam logic [1:0] ERR_MALFORMED = 2'd2;

    localparam logic CFG_MAX_BODY = 1'b0;
    localparam logic CFG_MAX_ARGS = 1'b1;

    localparam int          MAX_ARGS_W     = 18;
    localparam logic [31:0] MAX_BODY_RESET = 32'h0200_0000;
    localparam logic [MAX_ARGS_W-1:0] MAX_ARGS_RESET = 18'd200000;

    // Smallest body that still holds a length or count field.
    localparam logic [31:0] FIELD_BYTES = 32'd4;

endpackage

FILE: rtl/length_prefixed_request_deframer_top.sv
// Length-prefixed request deframer, top level.
// Depends on lprd_pkg and length_prefixed_request_deframer_top_assert.svh.
//
// Takes a byte stream of back-to-back requests (32-bit little-endian body
// length, 32-bit argument count, then per argument a 32-bit length and its
// bytes) and gives one result transaction per input byte: its role (control,
// payload, or dropped), the byte itself, the argument index, argument-end and
// request-end flags, the request's argument count and an error code. An error
// (body too long, or malformed: body too short, field past body end, too many
// arguments, trailing bytes) is flagged on the byte that makes it certain; from
// then on every byte is dropped until reset. Throughput is one byte per clock
// while input ready is high: the parser state advances on each accepted byte,
// and the result is registered into a two-entry output stage. The second entry
// lets the input keep flowing while the output is stalled; input ready drops
// only when both entries are full. Configuration must be written only while
// the block is idle; the block itself does not enforce this.
`default_nettype none

module length_prefixed_request_deframer_top #(
    parameter int ARG_INDEX_BITS = 18
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input byte stream
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [7:0]                i_stream_byte,
    // result stream
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [1:0]                     o_byte_role,
    output logic [7:0]                     o_payload,
    output logic [ARG_INDEX_BITS-1:0]      o_arg_index,
    output logic                           o_arg_end,
    output logic                           o_request_end,
    output logic [ARG_INDEX_BITS-1:0]      o_arg_total,
    output logic [1:0]                     o_error_code,
    // configuration writes
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_addr,
    input  wire logic [31:0]               i_cfg_data
);
    import lprd_pkg::*;

    `include "length_prefixed_request_deframer_top_assert.svh"

    localparam int IDX_W = ARG_INDEX_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0]           r_max_body;
    logic [MAX_ARGS_W-1:0] r_max_args;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body <= MAX_BODY_RESET;
            r_max_args <= MAX_ARGS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MAX_BODY: r_max_body <= i_cfg_data;
                CFG_MAX_ARGS: r_max_args <= i_cfg_data[MAX_ARGS_W-1:0];
                default:      r_max_body <= r_max_body;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    t_phase            r_phase,  n_phase;
    logic [1:0]        r_fbc,    n_fbc;      // bytes of current field seen
    logic [31:0]       r_shift,  n_shift;    // field value being assembled
    logic [31:0]       r_body,   n_body;     // body bytes not yet consumed
    logic [IDX_W-1:0]  r_args,   n_args;     // expected argument count
    logic [IDX_W-1:0]  r_cur,    n_cur;      // current argument index
    logic [31:0]       r_abl,    n_abl;      // payload bytes left in argument
    logic              r_halted, n_halted;

    // result of the byte being accepted
    logic [1:0]        res_role;
    logic [IDX_W-1:0]  res_idx;
    logic              res_aend;
    logic              res_rend;
    logic [IDX_W-1:0]  res_total;
    logic [1:0]        res_err;

    logic accept;
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        logic [31:0]      v;
        logic [31:0]      b_shifted;
        logic             do_finish;
        logic             done_ok;
        logic             done_bad;
        logic [IDX_W-1:0] cur_inc;

        n_phase   = r_phase;
        n_fbc     = r_fbc;
        n_shift   = r_shift;
        n_body    = r_body;
        n_args    = r_args;
        n_cur     = r_cur;
        n_abl     = r_abl;
        n_halted  = r_halted;
        v         = '0;
        b_shifted = {24'd0, i_stream_byte} << {r_fbc, 3'b000};
        do_finish = 1'b0;
        done_ok   = 1'b0;
        done_bad  = 1'b0;
        cur_inc   = r_cur + {{(IDX_W-1){1'b0}}, 1'b1};

        res_role  = ROLE_CTRL;
        res_idx   = r_cur;
        res_aend  = 1'b0;
        res_rend  = 1'b0;
        res_total = '0;
        res_err   = ERR_NONE;

        if (r_halted) begin
            res_role = ROLE_DROP;
            res_idx  = '0;
        end else begin
            if (r_phase == PH_PAYLOAD) begin
                res_role = ROLE_PAYLOAD;
                if (r_body != '0) n_body = r_body - 32'd1;
                if (r_abl != '0)  n_abl  = r_abl - 32'd1;
                do_finish = (n_abl == '0);
            end else begin
                if (r_phase != PH_BODY_LEN && r_body != '0) n_body = r_body - 32'd1;
                v     = r_shift | b_shifted;
                n_fbc = r_fbc + 2'd1;
                if (r_fbc != 2'd3) begin
                    n_shift = v;
                end else begin
                    n_shift = '0;
                    case (r_phase)
                        PH_BODY_LEN: begin
                            if (v > r_max_body) begin
                                res_err = ERR_TOO_LONG;
                            end else if (v < FIELD_BYTES) begin
                                res_err = ERR_MALFORMED;
                            end else begin
                                n_body  = v;
                                n_phase = PH_COUNT;
                            end
                        end
                        PH_COUNT: begin
                            if (v > {{(32-MAX_ARGS_W){1'b0}}, r_max_args}) begin
                                res_err = ERR_MALFORMED;
                            end else begin
                                n_args = v[IDX_W-1:0];
                                n_cur  = '0;
                                if (v[IDX_W-1:0] == '0) begin
                                    done_ok  = (n_body == '0);
                                    done_bad = (n_body != '0);
                                end else if (n_body < FIELD_BYTES) begin
                                    res_err = ERR_MALFORMED;
                                end else begin
                                    n_phase = PH_ARG_LEN;
                                end
                            end
                        end
                        default: begin
                            // argument length
                            if (v > n_body) begin
                                res_err = ERR_MALFORMED;
                            end else begin
                                n_abl = v;
                                if (v == '0) do_finish = 1'b1;
                                else         n_phase   = PH_PAYLOAD;
                            end
                        end
                    endcase
                end
            end

            // argument complete: advance the index, then last argument,
            // next length, or not enough room for another length
            if (do_finish) begin
                n_cur = cur_inc;
                if (cur_inc == r_args) begin
                    done_ok  = (n_body == '0);
                    done_bad = (n_body != '0);
                end else if (n_body < FIELD_BYTES) begin
                    done_bad = 1'b1;
                end else begin
                    n_phase = PH_ARG_LEN;
                    n_fbc   = '0;
                    n_shift = '0;
                end
            end

            if (done_bad) begin
                res_err = ERR_MALFORMED;
            end else if (done_ok) begin
                res_rend = 1'b1;
                res_aend = (n_args != '0);
            end else if (do_finish) begin
                res_aend = 1'b1;
            end

            res_total = n_args;

            if (res_err != ERR_NONE) begin
                n_halted = 1'b1;
            end else if (res_rend) begin
                // request complete: start over on the next body length
                n_phase = PH_BODY_LEN;
                n_fbc   = '0;
                n_shift = '0;
                n_body  = '0;
                n_args  = '0;
                n_cur   = '0;
                n_abl   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_BODY_LEN;
            r_fbc    <= '0;
            r_shift  <= '0;
            r_body   <= '0;
            r_args   <= '0;
            r_cur    <= '0;
            r_abl    <= '0;
            r_halted <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_fbc    <= n_fbc;
            r_shift  <= n_shift;
            r_body   <= n_body;
            r_args   <= n_args;
            r_cur    <= n_cur;
            r_abl    <= n_abl;
            r_halted <= n_halted;
        end
    end

    // ------------------------------------------------------------------
    // Two-entry output stage: main register drives the ports, skid entry
    // catches one transaction while the output is stalled.
    // ------------------------------------------------------------------
    logic              r_out_valid;
    logic              r_skid_valid;
    logic [1:0]        r_o_role,  r_s_role;
    logic [7:0]        r_o_byte,  r_s_byte;
    logic [IDX_W-1:0]  r_o_idx,   r_s_idx;
    logic              r_o_aend,  r_s_aend;
    logic              r_o_rend,  r_s_rend;
    logic [IDX_W-1:0]  r_o_total, r_s_total;
    logic [1:0]        r_o_err,   r_s_err;

    logic take;
    assign take       = r_out_valid && i_out_ready;
    assign o_in_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid || take) r_out_valid  <= 1'b1;
            else                      r_skid_valid <= 1'b1;
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload of the output stage, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_o_role  <= r_s_role;
                r_o_byte  <= r_s_byte;
                r_o_idx   <= r_s_idx;
                r_o_aend  <= r_s_aend;
                r_o_rend  <= r_s_rend;
                r_o_total <= r_s_total;
                r_o_err   <= r_s_err;
            end
        end else if (accept) begin
            if (!r_out_valid || take) begin
                r_o_role  <= res_role;
                r_o_byte  <= i_stream_byte;
                r_o_idx   <= res_idx;
                r_o_aend  <= res_aend;
                r_o_rend  <= res_rend;
                r_o_total <= res_total;
                r_o_err   <= res_err;
            end else begin
                r_s_role  <= res_role;
                r_s_byte  <= i_stream_byte;
                r_s_idx   <= res_idx;
                r_s_aend  <= res_aend;
                r_s_rend  <= res_rend;
                r_s_total <= res_total;
                r_s_err   <= res_err;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_byte_role   = r_o_role;
    assign o_payload     = r_o_byte;
    assign o_arg_index   = r_o_idx;
    assign o_arg_end     = r_o_aend;
    assign o_request_end = r_o_rend;
    assign o_arg_total   = r_o_total;
    assign o_error_code  = r_o_err;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LPRD_ASSERT_IMPL(a_skid_needs_main, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid entry full while main entry empty")
    `LPRD_ASSERT_NEXT(a_halt_sticks, i_clk, i_rst_n, r_halted, r_halted, "halt cleared without reset")
    `LPRD_ASSERT_NEXT(a_error_halts, i_clk, i_rst_n, accept && (res_err != ERR_NONE), r_halted, "error reported but parser not halted")
    `LPRD_ASSERT_IMPL(a_payload_has_bytes, i_clk, i_rst_n, !r_halted && (r_phase == PH_PAYLOAD), (r_abl != '0) && (r_fbc == '0), "payload phase with no bytes left or a partial field")

endmodule

`default_nettype wire

FILE: tb/lprd_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the length-prefixed request deframer: watches both streams and
// the configuration port, predicts each result and compares it. Depends on lprd_pkg.
module lprd_result_checker #(
    parameter int IDX_W = 18
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_ready,
    input  wire logic [7:0]       i_stream_byte,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  wire logic [1:0]       i_byte_role,
    input  wire logic [7:0]       i_payload,
    input  wire logic [IDX_W-1:0] i_arg_index,
    input  wire logic             i_arg_end,
    input  wire logic             i_request_end,
    input  wire logic [IDX_W-1:0] i_arg_total,
    input  wire logic [1:0]       i_error_code,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_addr,
    input  wire logic [31:0]      i_cfg_data,
    output int                    o_failures,
    output int                    o_pending
);
    import lprd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [1:0]       role;
        logic [7:0]       data;
        logic [IDX_W-1:0] index;
        logic             arg_last;
        logic             req_last;
        logic [IDX_W-1:0] total;
        logic [1:0]       err;
    } t_frame_byte;

    // Outcome of closing an argument.
    typedef enum logic [1:0] {
        ARG_OPEN,
        ARG_MORE,
        ARG_REQ_DONE,
        ARG_BROKEN
    } t_arg_close;

    t_frame_byte expected_bytes[$];

    logic [31:0]      max_body;
    logic [IDX_W-1:0] max_args;

    t_phase           parse_phase;
    logic [1:0]       field_cnt;
    logic [31:0]      field_acc;
    logic [31:0]      body_left;
    logic [IDX_W-1:0] args_wanted;
    logic [IDX_W-1:0] arg_now;
    logic [31:0]      arg_left;
    logic             halted;

    int failures;
    int results_seen;

    function automatic string describe(t_frame_byte r);
        return $sformatf("role %0d byte %02h idx %0d aend %0b rend %0b total %0d err %0d",
                         r.role, r.data, r.index, r.arg_last, r.req_last, r.total, r.err);
    endfunction

    task automatic begin_request();
        parse_phase = PH_BODY_LEN;
        field_cnt   = '0;
        field_acc   = '0;
        body_left   = '0;
        args_wanted = '0;
        arg_now     = '0;
        arg_left    = '0;
    endtask

    function automatic t_arg_close close_argument();
        arg_now = arg_now + IDX_W'(1);
        if (arg_now == args_wanted)
            return (body_left == 0) ? ARG_REQ_DONE : ARG_BROKEN;
        if (body_left < FIELD_BYTES)
            return ARG_BROKEN;
        parse_phase = PH_ARG_LEN;
        field_cnt   = '0;
        field_acc   = '0;
        return ARG_MORE;
    endfunction

    // Advance the parser by one stream byte and work out the result it gives.
    task automatic deframe_byte(input logic [7:0] in_byte, output t_frame_byte r);
        logic [31:0] field;
        t_arg_close  close;
        r      = '0;
        r.data = in_byte;
        close  = ARG_OPEN;
        if (halted) begin
            r.role = ROLE_DROP;
        end else begin
            r.role  = ROLE_CTRL;
            r.index = arg_now;
            r.err   = ERR_NONE;
            if (parse_phase == PH_PAYLOAD) begin
                r.role = ROLE_PAYLOAD;
                if (body_left != 0) body_left = body_left - 1;
                if (arg_left != 0) arg_left = arg_left - 1;
                if (arg_left == 0) close = close_argument();
            end else begin
                if (parse_phase != PH_BODY_LEN && body_left != 0) body_left = body_left - 1;
                field_acc = field_acc | ({24'd0, in_byte} << (8 * field_cnt));
                field_cnt = field_cnt + 2'd1;
                if (field_cnt == 0) begin
                    field     = field_acc;
                    field_acc = '0;
                    case (parse_phase)
                        PH_BODY_LEN: begin
                            if (field > max_body) begin
                                r.err = ERR_TOO_LONG;
                            end else if (field < FIELD_BYTES) begin
                                r.err = ERR_MALFORMED;
                            end else begin
                                body_left   = field;
                                parse_phase = PH_COUNT;
                            end
                        end
                        PH_COUNT: begin
                            if (field > 32'(max_args)) begin
                                r.err = ERR_MALFORMED;
                            end else begin
                                args_wanted = field[IDX_W-1:0];
                                arg_now     = '0;
                                if (args_wanted == 0)
                                    close = (body_left == 0) ? ARG_REQ_DONE : ARG_BROKEN;
                                else if (body_left < FIELD_BYTES)
                                    r.err = ERR_MALFORMED;
                                else
                                    parse_phase = PH_ARG_LEN;
                            end
                        end
                        default: begin
                            if (field > body_left) begin
                                r.err = ERR_MALFORMED;
                            end else begin
                                arg_left = field;
                                if (field == 0)
                                    close = close_argument();
                                else
                                    parse_phase = PH_PAYLOAD;
                            end
                        end
                    endcase
                end
            end
            case (close)
                ARG_BROKEN: r.err = ERR_MALFORMED;
                ARG_REQ_DONE: begin
                    r.req_last = 1'b1;
                    r.arg_last = (args_wanted != 0);
                end
                ARG_MORE: r.arg_last = 1'b1;
                default: ;
            endcase
            r.total = args_wanted;
            if (r.err != ERR_NONE)
                halted = 1'b1;
            else if (r.req_last)
                begin_request();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_byte want;
        t_frame_byte got;
        if (!i_rst_n) begin
            max_body = MAX_BODY_RESET;
            max_args = MAX_ARGS_RESET;
            halted   = 1'b0;
            begin_request();
            expected_bytes.delete();
            failures     = 0;
            results_seen = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MAX_BODY: max_body = i_cfg_data;
                    CFG_MAX_ARGS: max_args = i_cfg_data[IDX_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.role     = i_byte_role;
                got.data     = i_payload;
                got.index    = i_arg_index;
                got.arg_last = i_arg_end;
                got.req_last = i_request_end;
                got.total    = i_arg_total;
                got.err      = i_error_code;
                if (expected_bytes.size() == 0) begin
                    if (failures < REPORT_LIMIT)
                        $display("result %0d unexpected: %s", results_seen, describe(got));
                    failures++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.role !== want.role || got.data !== want.data ||
                        got.index !== want.index || got.arg_last !== want.arg_last ||
                        got.req_last !== want.req_last || got.total !== want.total ||
                        got.err !== want.err) begin
                        if (failures < REPORT_LIMIT)
                            $display("result %0d mismatch: expected %s, got %s",
                                     results_seen, describe(want), describe(got));
                        failures++;
                    end
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready) begin
                deframe_byte(i_stream_byte, want);
                expected_bytes.insert(expected_bytes.size(), want);
            end
        end
        o_pending  <= expected_bytes.size();
        o_failures <= failures;
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, request stream stimulus, result-side
// stalls and the verdict. Depends on lprd_pkg, the deframer top and lprd_result_checker.
module testbench;
    import lprd_pkg::*;

    localparam int ARG_IDX_W   = MAX_ARGS_W;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LEN_CAP     = 12;

    // Ways to end the clean traffic with one error; the halt is sticky until reset,
    // so each run closes with exactly one of these.
    typedef enum int {
        BREAK_TOO_LONG,
        BREAK_TOO_SHORT,
        BREAK_TOO_MANY_ARGS,
        BREAK_ARG_PAST_END,
        BREAK_NO_ROOM,
        BREAK_TRAILING,
        BREAK_NOISE,
        BREAK_KINDS
    } t_break_kind;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic [7:0]           i_stream_byte = 8'd0;
    logic                 i_out_ready   = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic                 i_cfg_addr    = CFG_MAX_BODY;
    logic [31:0]          i_cfg_data    = 32'd0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [1:0]           o_byte_role;
    logic [7:0]           o_payload;
    logic [ARG_IDX_W-1:0] o_arg_index;
    logic                 o_arg_end;
    logic                 o_request_end;
    logic [ARG_IDX_W-1:0] o_arg_total;
    logic [1:0]           o_error_code;

    int failure_count;
    int pending_results;

    // Traffic shaping: percent of cycles the sender idles and the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;

    // Long receiver hold-offs: the stimulus asks, the receiver process counts them out.
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;

    int unsigned cycle_count = 0;

    logic [7:0] stream_q[$];
    int         arg_len_q[$];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    length_prefixed_request_deframer_top #(
        .ARG_INDEX_BITS(ARG_IDX_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_stream_byte (i_stream_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_byte_role   (o_byte_role),
        .o_payload     (o_payload),
        .o_arg_index   (o_arg_index),
        .o_arg_end     (o_arg_end),
        .o_request_end (o_request_end),
        .o_arg_total   (o_arg_total),
        .o_error_code  (o_error_code),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    lprd_result_checker #(
        .IDX_W(ARG_IDX_W)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_stream_byte (i_stream_byte),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_byte_role   (o_byte_role),
        .i_payload     (o_payload),
        .i_arg_index   (o_arg_index),
        .i_arg_end     (o_arg_end),
        .i_request_end (o_request_end),
        .i_arg_total   (o_arg_total),
        .i_error_code  (o_error_code),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .o_failures    (failure_count),
        .o_pending     (pending_results)
    );

    // Receiver: serve a pending hold-off request first, then stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready  <= 1'b0;
            hold_left    <= 0;
            holds_served <= 0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_asked;
            hold_left    <= HOLD_CYCLES;
            i_out_ready  <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: end the run if it overruns the worst-case budget by far.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Add one byte at the tail of the stream.
    task automatic append_byte(input logic [7:0] b);
        stream_q.insert(stream_q.size(), b);
    endtask

    // Add one argument length at the tail of the pending request.
    task automatic append_arg_len(input int len);
        arg_len_q.insert(arg_len_q.size(), len);
    endtask

    // Append a 32-bit field, least significant byte first.
    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            append_byte(w[8*i +: 8]);
    endtask

    // Append a request whose argument lengths sit in arg_len_q; the body length is
    // given separately so broken requests can lie about it.
    task automatic append_request(input logic [31:0] body_len);
        push_word(body_len);
        push_word(arg_len_q.size());
        foreach (arg_len_q[i]) begin
            push_word(arg_len_q[i]);
            repeat (arg_len_q[i]) append_byte(8'($urandom_range(255)));
        end
    endtask

    // Build one well-formed request that fits the given limits, with random content.
    // Now and then fill the count or an argument up to the limit.
    task automatic make_request(input logic [31:0] body_lim, input int args_cap);
        int budget;
        int n;
        int len;
        int body;
        budget = (body_lim > 32'd4096) ? 4092 : int'(body_lim) - 4;
        n      = ($urandom_range(7) == 0) ? args_cap : $urandom_range(args_cap);
        body   = 4;
        arg_len_q.delete();
        for (int i = 0; i < n; i++) begin
            if (budget < 4) break;
            len = (budget - 4 < LEN_CAP) ? budget - 4 : LEN_CAP;
            if ($urandom_range(7) != 0) len = $urandom_range(len);
            append_arg_len(len);
            budget -= 4 + len;
            body   += 4 + len;
        end
        append_request(body);
    endtask

    // Offer one byte, idling first at the current rate; return once input ready reads high.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_stream_byte <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_stream();
        while (stream_q.size() != 0) send_byte(stream_q.pop_front());
    endtask

    // Drop valid and hold the sender until every predicted result has come out.
    // The checker's count is registered, so it lags behind the last transaction.
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both limits back to back; write enable stays high across the pair.
    task automatic program_limits(input logic [31:0] body_lim,
                                  input logic [ARG_IDX_W-1:0] args_lim);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_MAX_BODY;
        i_cfg_data <= body_lim;
        @(posedge i_clk);
        i_cfg_addr <= CFG_MAX_ARGS;
        i_cfg_data <= 32'(args_lim);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One phase of clean traffic: program the limits, set the traffic shape, stream
    // well-formed requests until the byte goal is met, then drain.
    task automatic run_phase(input logic [31:0] body_lim, input logic [ARG_IDX_W-1:0] args_lim,
                             input int send_idle, input int recv_stall, input int byte_goal,
                             input bit with_hold);
        int sent;
        int args_cap;
        program_limits(body_lim, args_lim);
        idle_pct  = send_idle;
        stall_pct <= recv_stall;
        args_cap  = (args_lim > 5) ? 5 : int'(args_lim);
        // Stall the result side for a long stretch while bytes keep coming, so the
        // output stage fills and input ready drops.
        if (with_hold) holds_asked <= holds_asked + 1;
        sent = 0;
        while (sent < byte_goal) begin
            make_request(body_lim, args_cap);
            sent += stream_q.size();
            send_stream();
        end
        wait_results_done();
    endtask

    // Close the run with one broken request picked at random, then bytes that the
    // halted block must drop.
    task automatic break_stream();
        t_break_kind kind;
        int          k;
        kind = t_break_kind'($urandom_range(int'(BREAK_KINDS) - 1));
        if (kind == BREAK_NOISE)
            program_limits(32'd0, '0);
        else
            program_limits(32'd64, 18'd3);
        idle_pct  = 11;
        stall_pct <= 11;
        if (kind != BREAK_NOISE) make_request(32'd64, 3);
        case (kind)
            BREAK_TOO_LONG: begin
                push_word($urandom_range(1) ? 32'hFFFF_FFFF : 32'd65 + $urandom_range(1000));
            end
            BREAK_TOO_SHORT: begin
                push_word($urandom_range(3));
            end
            BREAK_TOO_MANY_ARGS: begin
                push_word(32'd64);
                push_word($urandom_range(1) ? 32'hFFFF_FFFF : 32'd4 + $urandom_range(100));
            end
            BREAK_ARG_PAST_END: begin
                // One argument whose length overruns what is left of the body.
                k = $urandom_range(8);
                arg_len_q.delete();
                append_arg_len(k + 1 + $urandom_range(3));
                append_request(8 + k);
            end
            BREAK_NO_ROOM: begin
                // Two arguments, but after the first fewer than four body bytes remain.
                k = $urandom_range(6);
                arg_len_q.delete();
                append_arg_len(k);
                append_arg_len(1);
                append_request(8 + k + $urandom_range(3));
            end
            BREAK_TRAILING: begin
                // Body longer than its arguments need; a zero count is included.
                k = 4;
                arg_len_q.delete();
                repeat ($urandom_range(2)) begin
                    append_arg_len($urandom_range(5));
                    k += 4 + arg_len_q[arg_len_q.size() - 1];
                end
                append_request(k + 1 + $urandom_range(5));
            end
            default: begin
                repeat (40) append_byte(8'($urandom_range(255)));
            end
        endcase
        repeat (20) append_byte(8'($urandom_range(255)));
        send_stream();
        wait_results_done();
    endtask

    initial begin
        // Hold reset at the start, then release it once for the whole run.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset limits: a zero-count request, then an empty argument
        // followed by an argument carrying the byte extremes.
        push_word(32'd4);
        push_word(32'd0);
        push_word(32'd14);
        push_word(32'd2);
        push_word(32'd0);
        push_word(32'd2);
        append_byte(8'h00);
        append_byte(8'hFF);
        send_stream();
        wait_results_done();

        // Random clean traffic over several limit settings and traffic shapes.
        run_phase(32'hFFFF_FFFF, 18'h3FFFF, 0, 0, 280, 1'b0);
        run_phase(32'd4, 18'd0, 68, 0, 140, 1'b0);
        run_phase(32'd60, 18'd3, 0, 68, 280, 1'b1);
        run_phase(MAX_BODY_RESET, MAX_ARGS_RESET, 11, 11, 280, 1'b0);
        run_phase(32'd40 + $urandom_range(160), 18'(1 + $urandom_range(5)), 0, 0, 280, 1'b0);

        break_stream();

        if (failure_count == 0 && pending_results == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
